>>> hw/rtl/orgbp_pkg.sv
// Package for the OR-indexed global history branch predictor.
// Holds the history type, the operation codes, the configuration register indexes
// and the history update command. No dependencies.
`default_nettype none

package orgbp_pkg;

    localparam int HIST_WIDTH = 12;

    typedef logic [HIST_WIDTH-1:0] t_hist;

    typedef enum logic [2:0] {
        OP_LOOKUP      = 3'd0,
        OP_UNCOND      = 3'd1,
        OP_RESOLVE     = 3'd2,
        OP_RESOLVE_SQ  = 3'd3,
        OP_SQUASH      = 3'd4,
        OP_BTB_MISS    = 3'd5
    } t_op;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_HISTORY_BITS  = 2'd0;
    localparam logic [1:0] CFG_COUNTER_BITS  = 2'd1;
    localparam logic [1:0] CFG_ADDRESS_SHIFT = 2'd2;

    // History update issued by the completion stage.
    typedef struct packed {
        logic       en;
        t_op        op;
        logic [1:0] thread;
        logic       taken;
        logic       pred;
        t_hist      saved;
        t_hist      cur;
    } t_hist_cmd;

endpackage

`default_nettype wire

>>> hw/rtl/orgbp_pht.sv
// Pattern history table: synchronous counter memory with one read and one write port.
// Runs a clearing pass over every entry after reset. Depends on nothing else.
`default_nettype none

module orgbp_pht #(
    parameter int INDEX_BITS    = 12,
    parameter int COUNTER_WIDTH = 8
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_rd_en,
    input  wire  [INDEX_BITS-1:0]     i_rd_addr,
    output logic [COUNTER_WIDTH-1:0]  o_rd_data,
    input  wire                       i_wr_en,
    input  wire  [INDEX_BITS-1:0]     i_wr_addr,
    input  wire  [COUNTER_WIDTH-1:0]  i_wr_data,
    output logic                      o_busy
);

    localparam int DEPTH = 1 << INDEX_BITS;

    logic [COUNTER_WIDTH-1:0] r_mem [DEPTH];
    logic [COUNTER_WIDTH-1:0] r_rd_data;
    logic [INDEX_BITS-1:0]    r_clr_addr;
    logic                     r_clr_active;

    // Clearing pass: one entry per cycle until the last address is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_active;

endmodule

`default_nettype wire

>>> hw/rtl/orgbp_hist.sv
// Per-thread global history registers with their update logic.
// Uses orgbp_pkg for the history type, operation codes and update command.
`default_nettype none

module orgbp_hist
    import orgbp_pkg::*;
#(
    parameter int NUM_THREADS = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire  [1:0] i_rd_thread,
    output t_hist      o_hist,
    input  t_hist      i_mask,
    input  t_hist_cmd  i_cmd
);

    localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

    t_hist r_hist [NUM_THREADS];
    t_hist n_hist;
    logic  n_we;
    logic  rd_ok;

    assign rd_ok  = 32'(i_rd_thread) < 32'(NUM_THREADS);
    assign o_hist = rd_ok ? r_hist[TW'(i_rd_thread)] : '0;

    always_comb begin
        n_we   = i_cmd.en;
        n_hist = i_cmd.cur;
        case (i_cmd.op)
            OP_LOOKUP:     n_hist = {i_cmd.cur[HIST_WIDTH-2:0], i_cmd.pred} & i_mask;
            OP_UNCOND:     n_hist = {i_cmd.cur[HIST_WIDTH-2:0], 1'b1} & i_mask;
            OP_RESOLVE_SQ: n_hist = {i_cmd.saved[HIST_WIDTH-2:0], i_cmd.taken} & i_mask;
            OP_SQUASH:     n_hist = i_cmd.saved;
            OP_BTB_MISS:   n_hist = i_cmd.cur & i_mask & ~t_hist'(1);
            default:       n_we   = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_THREADS; i++) begin
                r_hist[i] <= '0;
            end
        end else if (n_we) begin
            r_hist[TW'(i_cmd.thread)] <= n_hist;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/or_indexed_global_branch_predictor.sv
// Top level of the OR-indexed global history branch predictor.
// Uses orgbp_pkg, orgbp_pht (counter table) and orgbp_hist (thread histories).
//
// Each accepted item is one operation chosen by its opcode: lookup, unconditional
// branch, resolve, squashed resolve, squash or BTB miss, and each gives exactly one
// result item. A lookup indexes the counter table with ((branch address >> shift)
// OR thread history), masked to the history length, predicts taken when the
// counter is at least half its range, returns the history it saw and shifts the
// prediction into that thread's history. A resolve saturates the counter at the
// index formed from the saved history. An item has two steps: the edge that
// accepts it issues the read of the synchronous counter memory, and the next
// edge writes the counter or history back and loads the result register; the
// block does not accept a new item while one is in flight. A result held by the
// output side keeps the input stalled; the next item may enter at the edge where
// the waiting result leaves. After reset the counter table is cleared one entry
// per cycle over all 2^INDEX_BITS entries (4096 by default), and no item is
// accepted until that pass is done; configuration writes are taken at any time.
`default_nettype none

module or_indexed_global_branch_predictor
    import orgbp_pkg::*;
#(
    parameter int INDEX_BITS    = 12,
    parameter int NUM_THREADS   = 4,
    parameter int COUNTER_WIDTH = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write port.
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [3:0]  i_cfg_wdata,
    // Input channel.
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [2:0]  i_opcode,
    input  wire  [1:0]  i_thread,
    input  wire  [31:0] i_branch_address,
    input  wire         i_taken,
    input  wire  [11:0] i_saved_history,
    // Output channel.
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_predict_taken,
    output logic [11:0] o_history_snapshot
);

    localparam int HB_MAX = (INDEX_BITS < HIST_WIDTH) ? INDEX_BITS : HIST_WIDTH;
    localparam int CW     = COUNTER_WIDTH;

    // Configuration registers.
    logic [3:0] r_history_bits;
    logic [3:0] r_counter_bits;
    logic [1:0] r_address_shift;

    // Item in flight between the memory read and the write-back.
    logic                  r_s1_valid;
    t_op                   r_s1_op;
    logic                  r_s1_thr_ok;
    logic [1:0]            r_s1_thread;
    logic                  r_s1_taken;
    t_hist                 r_s1_saved;
    t_hist                 r_s1_hist;
    logic [INDEX_BITS-1:0] r_s1_idx;

    // Result register.
    logic                  r_out_valid;
    logic                  r_out_pred;
    t_hist                 r_out_snap;

    logic                  accept;
    logic                  pht_busy;
    logic                  thr_ok;
    t_op                   in_op;
    t_hist                 cur_hist;
    t_hist                 idx_hist;
    t_hist                 addr_bits;
    t_hist                 hist_mask;
    logic [3:0]            hb_eff;
    logic [3:0]            cb_eff;
    logic [CW-1:0]         ctr_max;
    logic [CW-1:0]         ctr_thr;
    logic [CW-1:0]         ctr;
    logic [CW-1:0]         ctr_new;
    logic [INDEX_BITS-1:0] rd_idx;
    logic                  pht_we;
    logic                  n_pred;
    t_hist                 n_snap;
    t_hist_cmd             hist_cmd;

    // The input side waits for the previous item to finish, for the clearing
    // pass, and for a result that the output side is still holding.
    assign o_in_stall = r_s1_valid | pht_busy | (r_out_valid & i_out_stall);
    assign accept     = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history_bits  <= 4'd6;
            r_counter_bits  <= 4'd2;
            r_address_shift <= 2'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HISTORY_BITS:  r_history_bits  <= i_cfg_wdata;
                CFG_COUNTER_BITS:  r_counter_bits  <= i_cfg_wdata;
                CFG_ADDRESS_SHIFT: r_address_shift <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Effective history length clamps to one at the bottom and to the table
    // index width or the history register width at the top.
    always_comb begin
        if (r_history_bits == 4'd0) begin
            hb_eff = 4'd1;
        end else if (32'(r_history_bits) > 32'(HB_MAX)) begin
            hb_eff = 4'(HB_MAX);
        end else begin
            hb_eff = r_history_bits;
        end
        for (int i = 0; i < HIST_WIDTH; i++) begin
            hist_mask[i] = 4'(i) < hb_eff;
        end
    end

    // Counter width clamps the same way; it sets the saturation value and the
    // taken threshold, which is half the range minus one.
    always_comb begin
        if (r_counter_bits == 4'd0) begin
            cb_eff = 4'd1;
        end else if (32'(r_counter_bits) > 32'(CW)) begin
            cb_eff = 4'(CW);
        end else begin
            cb_eff = r_counter_bits;
        end
        for (int i = 0; i < CW; i++) begin
            ctr_max[i] = 4'(i) < cb_eff;
            ctr_thr[i] = 4'(i) < (cb_eff - 4'd1);
        end
    end

    // Index formation at accept time. A resolve indexes with the history that
    // its lookup handed out; everything else with the thread's live history.
    assign in_op     = t_op'(i_opcode);
    assign thr_ok    = 32'(i_thread) < 32'(NUM_THREADS);
    assign addr_bits = HIST_WIDTH'(i_branch_address >> r_address_shift);
    assign idx_hist  = (in_op == OP_RESOLVE) ? i_saved_history : cur_hist;
    assign rd_idx    = INDEX_BITS'((addr_bits | idx_hist) & hist_mask);

    orgbp_hist #(
        .NUM_THREADS (NUM_THREADS)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_thread (i_thread),
        .o_hist      (cur_hist),
        .i_mask      (hist_mask),
        .i_cmd       (hist_cmd)
    );

    orgbp_pht #(
        .INDEX_BITS    (INDEX_BITS),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_pht (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_idx),
        .o_rd_data (ctr),
        .i_wr_en   (pht_we),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (ctr_new),
        .o_busy    (pht_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op     <= in_op;
            r_s1_thr_ok <= thr_ok;
            r_s1_thread <= i_thread;
            r_s1_taken  <= i_taken;
            r_s1_saved  <= i_saved_history;
            r_s1_hist   <= cur_hist;
            r_s1_idx    <= rd_idx;
        end
    end

    // Completion stage: the counter read is back. A counter left above the
    // maximum by a narrower width setting is not raised, only lowered.
    always_comb begin
        if (r_s1_taken) begin
            ctr_new = (ctr < ctr_max) ? ctr + 1'b1 : ctr;
        end else begin
            ctr_new = (ctr != '0) ? ctr - 1'b1 : ctr;
        end
    end

    assign pht_we = r_s1_valid & r_s1_thr_ok & (r_s1_op == OP_RESOLVE);

    always_comb begin
        n_pred = 1'b0;
        n_snap = '0;
        if (r_s1_thr_ok) begin
            case (r_s1_op)
                OP_LOOKUP: begin
                    n_pred = ctr > ctr_thr;
                    n_snap = r_s1_hist;
                end
                OP_UNCOND: begin
                    n_pred = 1'b1;
                    n_snap = r_s1_hist & hist_mask;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        hist_cmd.en     = r_s1_valid & r_s1_thr_ok;
        hist_cmd.op     = r_s1_op;
        hist_cmd.thread = r_s1_thread;
        hist_cmd.taken  = r_s1_taken;
        hist_cmd.pred   = n_pred;
        hist_cmd.saved  = r_s1_saved;
        hist_cmd.cur    = r_s1_hist;
    end

    // The accept condition guarantees the result register is free whenever
    // the completion stage loads it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_out_pred <= n_pred;
            r_out_snap <= n_snap;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_predict_taken    = r_out_pred;
    assign o_history_snapshot = r_out_snap;

endmodule

`default_nettype wire
